// ===== rtl/qst_pkg.sv =====
// ============================================================================
// qst_pkg
// Shared types and constants of the statement tokenizer.
// ============================================================================
package qst_pkg;

  localparam int unsigned MaxStatementBytes = 4096;
  localparam int unsigned OffW = 13;
  localparam int unsigned LongestKeyword = 7;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_ERROR   = 5'd1;
  localparam logic [4:0] K_NUM     = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_ID      = 5'd4;
  localparam logic [4:0] K_TABLE   = 5'd5;
  localparam logic [4:0] K_KEY     = 5'd6;
  localparam logic [4:0] K_PUNCT   = 5'd7;
  localparam logic [4:0] K_KEYWORD0 = 5'd8;

  localparam logic [31:0] ERR_UTF8   = 32'd0;
  localparam logic [31:0] ERR_STRING = 32'd1;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_K     = 8'h6B;

  localparam logic [1:0] CFG_IDS_ONLY = 2'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_value;
    logic [11:0] text_offset;
    logic [12:0] text_length;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last_of_run;
  } tok_t;

  // Up to three tokens produced by one input item.
  typedef struct packed {
    logic [1:0] count;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } tok_group_t;

  function automatic logic [55:0] kw_packed(input logic [3:0] i);
    logic [55:0] r;
    r = '0;
    unique case (i)
      4'd0:  r = 56'h50494E47;
      4'd1:  r = 56'h555044415445;
      4'd2:  r = 56'h534554;
      4'd3:  r = 56'h5748455245;
      4'd4:  r = 56'h53504C494345;
      4'd5:  r = 56'h44454C455445;
      4'd6:  r = 56'h46524F4D;
      4'd7:  r = 56'h494E53455254;
      4'd8:  r = 56'h5245504C414345;
      4'd9:  r = 56'h494E544F;
      4'd10: r = 56'h56414C554553;
      4'd11: r = 56'h53454C454354;
      4'd12: r = 56'h4F52;
      4'd13: r = 56'h414E44;
      4'd14: r = 56'h4C494D4954;
      default: r = 56'h43414C4C;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] i);
    logic [3:0] r;
    unique case (i)
      4'd0, 4'd6, 4'd9, 4'd15: r = 4'd4;
      4'd2, 4'd13: r = 4'd3;
      4'd3, 4'd14: r = 4'd5;
      4'd8: r = 4'd7;
      4'd12: r = 4'd2;
      default: r = 4'd6;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qst_if.sv =====
// ============================================================================
// qst_stream_if
// Valid/ready channel carrying one payload beat.
// ============================================================================
interface qst_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/qst_front.sv =====
// ============================================================================
// qst_front
// Scanner: one byte per cycle unless stalled; makes a group of 0..3 tokens.
// ============================================================================
module qst_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ids_only,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qst_pkg::in_beat_t    in_beat,
  output logic                 grp_valid,
  input  logic                 grp_ready,
  output qst_pkg::tok_group_t  grp
);
  import qst_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_STRING, M_MINUS, M_NUMBER, M_WORD, M_HALTED
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [12:0] off_r, off_nxt;
  logic [15:0] line_r, line_nxt, col_r, col_nxt;
  logic [12:0] soff_r, soff_nxt;
  logic [15:0] sline_r, sline_nxt, scol_r, scol_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [55:0] pre_r, pre_nxt;
  logic [1:0]  idc_r, idc_nxt;
  logic [1:0]  u8_r, u8_nxt;
  logic        gv_r;
  tok_group_t  grp_r, grp_nxt;

  logic fire;
  assign in_ready = !gv_r || grp_ready;
  assign fire = in_valid && in_ready;
  assign grp_valid = gv_r;
  assign grp = grp_r;

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction
  function automatic logic is_pun(input logic [7:0] b);
    return ((b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
            (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E)) && b != CH_UNDER;
  endfunction
  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
  endfunction
  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction
  function automatic logic [31:0] mul10add(input logic [31:0] a, input logic [7:0] b);
    return (a << 3) + (a << 1) + {28'd0, b[3:0]};
  endfunction

  tok_t        tk [3];
  logic [1:0]  n;

  always_comb begin
    logic [7:0]  b;
    logic        pres, fin, cont, halt, idle_go, fin_go;
    logic [12:0] off, len, wlen;
    logic [15:0] ln, cl;
    logic        kw_hit;
    logic [3:0]  kw_i;
    tok_t        t;
    b = in_beat.data_byte;
    pres = in_beat.byte_present;
    fin = in_beat.final_byte;
    mode_nxt = mode_r; off_nxt = off_r; line_nxt = line_r; col_nxt = col_r;
    soff_nxt = soff_r; sline_nxt = sline_r; scol_nxt = scol_r;
    acc_nxt = acc_r; neg_nxt = neg_r; pre_nxt = pre_r; idc_nxt = idc_r; u8_nxt = u8_r;
    tk[0] = '0; tk[1] = '0; tk[2] = '0;
    n = 2'd0;
    cont = 1'b0; halt = 1'b0; idle_go = 1'b0; fin_go = 1'b0;
    off = off_r; ln = line_r; cl = col_r; len = '0; wlen = '0;
    kw_hit = 1'b0; kw_i = '0; t = '0;
    if (mode_r != M_HALTED) begin
      if (pres) begin
        if (u8_r != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            halt = 1'b1;
          end else begin
            u8_nxt = u8_r - 2'd1;
            cont = 1'b1;
          end
        end else if (b[7]) begin
          if (b < 8'hC0 || b >= 8'hF8) begin
            halt = 1'b1;
          end else begin
            u8_nxt = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
          end
        end
        if (halt) begin
          t = '0; t.token_kind = K_ERROR; t.token_value = ERR_UTF8;
          t.token_line = line_r; t.token_column = col_r;
          tk[0] = t; n = 2'd1; mode_nxt = M_HALTED;
        end else begin
          if (!cont) col_nxt = (off_r == '0) ? 16'd1 : sat16(col_r);
          cl = col_nxt;
          unique case (mode_r)
            M_COMMENT: if (!cont && b == CH_NL) mode_nxt = M_IDLE;
            M_STRING: begin
              if (!cont && b == CH_QUOTE) begin
                t = '0; t.token_kind = K_STRING; t.text_offset = soff_r[11:0];
                len = off - soff_r;
                t.text_length = len;
                t.token_line = sline_r; t.token_column = scol_r;
                tk[0] = t; n = 2'd1; mode_nxt = M_IDLE;
              end else if (!cont && b == CH_NL) begin
                t = '0; t.token_kind = K_ERROR; t.token_value = ERR_STRING;
                t.token_line = line_r; t.token_column = cl;
                tk[0] = t; n = 2'd1; mode_nxt = M_HALTED; halt = 1'b1;
              end
            end
            M_MINUS: begin
              if (!cont && is_dig(b)) begin
                mode_nxt = M_NUMBER; acc_nxt = {28'd0, b[3:0]}; neg_nxt = 1'b1;
              end else begin
                fin_go = 1'b1; idle_go = 1'b1;
              end
            end
            M_NUMBER: begin
              if (!cont && is_dig(b)) acc_nxt = mul10add(acc_r, b);
              else begin
                fin_go = 1'b1; idle_go = 1'b1;
              end
            end
            M_WORD: begin
              if (cont || !(is_space(b) || is_pun(b))) begin
                if (off - soff_r < 13'(LongestKeyword))
                  pre_nxt = {pre_r[47:0], fold(b)};
                if (idc_r != 2'd0) begin
                  if (!cont && is_dig(b)) acc_nxt = mul10add(acc_r, b);
                  else idc_nxt = 2'd0;
                end
              end else begin
                fin_go = 1'b1; idle_go = 1'b1;
              end
            end
            default: idle_go = 1'b1;
          endcase
        end
      end
      if (!halt && fin_go) begin
        t = '0; t.token_line = sline_r; t.token_column = scol_r;
        wlen = off - soff_r;
        if (mode_r == M_MINUS) begin
          t.token_kind = K_PUNCT; t.token_value = {24'd0, CH_MINUS};
        end else if (mode_r == M_NUMBER) begin
          t.token_kind = K_NUM; t.token_value = neg_r ? 32'd0 - acc_r : acc_r;
        end else begin
          for (int i = 15; i >= 0; i--) begin
            if (wlen == 13'(kw_len(4'(i))) && pre_r == kw_packed(4'(i))) begin
              kw_hit = 1'b1; kw_i = 4'(i);
            end
          end
          if (!ids_only && kw_hit) t.token_kind = K_KEYWORD0 + {1'b0, kw_i};
          else if (!ids_only && idc_r != 2'd0 && wlen >= 13'd2) begin
            t.token_kind = (idc_r == 2'd1) ? K_TABLE : K_KEY; t.token_value = acc_r;
          end else begin
            t.token_kind = K_ID; t.text_offset = soff_r[11:0]; t.text_length = wlen;
          end
        end
        tk[n] = t; n = n + 2'd1; mode_nxt = M_IDLE;
      end
      if (!halt && idle_go) begin
        mode_nxt = M_IDLE;
        if (cont || !is_space(b)) begin
          if (!cont && b == CH_HASH) mode_nxt = M_COMMENT;
          else if (!cont && b == CH_QUOTE) begin
            mode_nxt = M_STRING; soff_nxt = off + 13'd1; sline_nxt = ln; scol_nxt = cl;
          end else if (!cont && is_pun(b)) begin
            if (b == CH_MINUS) begin
              mode_nxt = M_MINUS; soff_nxt = off; sline_nxt = ln; scol_nxt = cl;
            end else begin
              t = '0; t.token_kind = K_PUNCT; t.token_value = {24'd0, b};
              t.token_line = ln; t.token_column = cl; tk[n] = t; n = n + 2'd1;
            end
          end else if (!cont && is_dig(b)) begin
            mode_nxt = M_NUMBER; soff_nxt = off; sline_nxt = ln; scol_nxt = cl;
            acc_nxt = {28'd0, b[3:0]}; neg_nxt = 1'b0;
          end else begin
            mode_nxt = M_WORD; soff_nxt = off; sline_nxt = ln; scol_nxt = cl;
            pre_nxt = {48'd0, fold(b)};
            idc_nxt = (!cont && b == CH_T) ? 2'd1 : (!cont && b == CH_K) ? 2'd2 : 2'd0;
            acc_nxt = '0;
          end
        end
      end
      if (!halt && pres) begin
        if (!cont && b == CH_NL) begin
          if (!fin) line_nxt = sat16(line_r);
          col_nxt = '0;
        end
        off_nxt = (off < 13'(MaxStatementBytes)) ? off + 13'd1 : off;
      end
      if (!halt && fin) begin
        if (u8_nxt != 2'd0 || mode_nxt == M_STRING) begin
          t = '0; t.token_kind = K_ERROR;
          t.token_value = (u8_nxt != 2'd0) ? ERR_UTF8 : ERR_STRING;
          t.token_line = line_nxt; t.token_column = col_nxt;
          tk[n] = t; n = n + 2'd1; mode_nxt = M_HALTED;
        end else begin
          if (mode_nxt == M_MINUS || mode_nxt == M_NUMBER || mode_nxt == M_WORD) begin
            t = '0; t.token_line = sline_nxt; t.token_column = scol_nxt;
            wlen = off_nxt - soff_nxt;
            if (mode_nxt == M_MINUS) begin
              t.token_kind = K_PUNCT; t.token_value = {24'd0, CH_MINUS};
            end else if (mode_nxt == M_NUMBER) begin
              t.token_kind = K_NUM; t.token_value = neg_nxt ? 32'd0 - acc_nxt : acc_nxt;
            end else begin
              kw_hit = 1'b0; kw_i = '0;
              for (int i = 15; i >= 0; i--) begin
                if (wlen == 13'(kw_len(4'(i))) && pre_nxt == kw_packed(4'(i))) begin
                  kw_hit = 1'b1; kw_i = 4'(i);
                end
              end
              if (!ids_only && kw_hit) t.token_kind = K_KEYWORD0 + {1'b0, kw_i};
              else if (!ids_only && idc_nxt != 2'd0 && wlen >= 13'd2) begin
                t.token_kind = (idc_nxt == 2'd1) ? K_TABLE : K_KEY;
                t.token_value = acc_nxt;
              end else begin
                t.token_kind = K_ID; t.text_offset = soff_nxt[11:0]; t.text_length = wlen;
              end
            end
            tk[n] = t; n = n + 2'd1;
          end
          t = '0; t.token_kind = K_END; t.token_line = line_nxt; t.token_column = col_nxt;
          tk[n] = t; n = n + 2'd1;
          mode_nxt = M_IDLE; off_nxt = '0; line_nxt = 16'd1; col_nxt = 16'd1;
          soff_nxt = '0; sline_nxt = 16'd1; scol_nxt = 16'd1; acc_nxt = '0;
          neg_nxt = 1'b0; pre_nxt = '0; idc_nxt = 2'd0; u8_nxt = 2'd0;
        end
      end
    end
    if (n != 2'd0) tk[n - 2'd1].last_of_run = 1'b1;
    grp_nxt.count = n;
    grp_nxt.t0 = tk[0];
    grp_nxt.t1 = tk[1];
    grp_nxt.t2 = tk[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; off_r <= '0; line_r <= 16'd1; col_r <= 16'd1;
      soff_r <= '0; sline_r <= 16'd1; scol_r <= 16'd1; acc_r <= '0; neg_r <= 1'b0;
      pre_r <= '0; idc_r <= '0; u8_r <= '0; gv_r <= 1'b0;
    end else begin
      if (grp_ready) gv_r <= 1'b0;
      if (fire) begin
        mode_r <= mode_nxt; off_r <= off_nxt; line_r <= line_nxt; col_r <= col_nxt;
        soff_r <= soff_nxt; sline_r <= sline_nxt; scol_r <= scol_nxt;
        acc_r <= acc_nxt; neg_r <= neg_nxt; pre_r <= pre_nxt; idc_r <= idc_nxt;
        u8_r <= u8_nxt;
        gv_r <= (n != 2'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) grp_r <= grp_nxt;
  end
endmodule

// ===== rtl/qst_back.sv =====
// ============================================================================
// qst_back
// Token queue and serializer: buffers token groups and emits one token per beat.
// ============================================================================
module qst_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  output logic                grp_ready,
  input  qst_pkg::tok_group_t grp,
  output logic                out_valid,
  input  logic                out_ready,
  output qst_pkg::tok_t       out_tok
);
  import qst_pkg::*;

  // Four-entry token queue; a group of up to three enters when room allows.
  tok_t       q_r [4];
  logic [1:0] rd_r, wr_r;
  logic [2:0] cnt_r;
  logic       pop, push;
  logic [2:0] room;

  assign room = 3'd4 - cnt_r;
  assign grp_ready = room >= {1'b0, grp.count};
  assign push = grp_valid && grp_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_tok = q_r[rd_r];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      if (pop) rd_r <= rd_r + 2'd1;
      if (push) wr_r <= wr_r + grp.count;
      cnt_r <= cnt_r + (push ? {1'b0, grp.count} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (grp.count >= 2'd1) q_r[wr_r] <= grp.t0;
      if (grp.count >= 2'd2) q_r[wr_r + 2'd1] <= grp.t1;
      if (grp.count == 2'd3) q_r[wr_r + 2'd2] <= grp.t2;
    end
  end
endmodule

// ===== rtl/query_statement_tokenizer.sv =====
// ============================================================================
// query_statement_tokenizer
// Byte-stream statement tokenizer with a scanner front and a token queue back.
// ============================================================================
// Channel | Direction | Beat
// in      | sink      | data_byte, byte_present, final_byte
// out     | source    | one token per beat
// cfg     | APB       | ids_only at byte address 0
//
// One input byte is accepted per cycle while the scanner's group register is free or being taken.
// The first token of a byte passes through the scanner's group register and then the token queue before out.
// An item producing several tokens delivers them over that many output beats.
// The input stalls while a held group does not fit in the four-token queue.
// Reset is synchronous, active low, and restores the start of a statement.
module query_statement_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  qst_stream_if.sink   in_ch,
  qst_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import qst_pkg::*;

  logic       ids_only_r;
  logic       gv, gr;
  tok_group_t grp;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {CFG_IDS_ONLY[1:0]}) ? {31'd0, ids_only_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_only_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == CFG_IDS_ONLY) begin
      ids_only_r <= cfg_pwdata[0];
    end
  end

  qst_front u_front (
    .clk, .rst_n, .ids_only(ids_only_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_beat(in_ch.payload),
    .grp_valid(gv), .grp_ready(gr), .grp(grp)
  );

  qst_back u_back (
    .clk, .rst_n, .grp_valid(gv), .grp_ready(gr), .grp(grp),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_tok(out_ch.payload)
  );

  a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    gv |-> grp.count != 2'd0) else $error("empty token group queued");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    gv && !gr |=> gv && $stable(grp)) else $error("token group lost");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    gv |-> (grp.count == 2'd1 && grp.t0.last_of_run) ||
           (grp.count == 2'd2 && grp.t1.last_of_run) ||
           (grp.count == 2'd3 && grp.t2.last_of_run)) else $error("last mark misplaced");
endmodule
